[hw/rtl/nfca_pkg.sv]
// Shared types, codes and helper functions for the type A anticollision sequencer.
package nfca_pkg;

    // Sequencer phases, one-hot
    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_ATQA = 5'b00010,
        PH_AC   = 5'b00100,
        PH_SAK  = 5'b01000,
        PH_HALT = 5'b10000
    } phase_t;

    // Request types
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_REPLY = 1'b1;

    // Transceiver reply status
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TX_ERR     = 3'd1;
    localparam logic [2:0] ST_TX_TIMEOUT = 3'd2;
    localparam logic [2:0] ST_RX_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_RX_COLL    = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_FRAME  = 2'd0;
    localparam logic [1:0] KIND_UID    = 2'd1;
    localparam logic [1:0] KIND_FOUND  = 2'd2;
    localparam logic [1:0] KIND_FAILED = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TX_FAIL   = 3'd1;
    localparam logic [2:0] ERR_NO_REPLY  = 3'd2;
    localparam logic [2:0] ERR_BCC       = 3'd3;
    localparam logic [2:0] ERR_SAK_CRC   = 3'd4;
    localparam logic [2:0] ERR_SEL_COLL  = 3'd5;
    localparam logic [2:0] ERR_CASC_OVF  = 3'd6;
    localparam logic [2:0] ERR_OTHER     = 3'd7;

    // Protocol constants
    localparam logic [7:0]  CMD_REQA     = 8'h26;
    localparam logic [7:0]  CMD_HLTA     = 8'h50;
    localparam logic [7:0]  SEL_CL1      = 8'h93;
    localparam logic [7:0]  NVB_START    = 8'h20;
    localparam logic [7:0]  NVB_FULL     = 8'h70;
    localparam logic [15:0] CRC_A_PRESET = 16'h6363;
    localparam logic [1:0]  LEVEL_FIRST  = 2'd1;
    localparam logic [1:0]  LEVEL_LAST   = 2'd3;
    localparam int          SAK_CASC_BIT = 2;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [55:0] frame_data;
        logic [2:0]  frame_bytes;
        logic [2:0]  frame_last_bits;
        logic        append_crc;
        logic [31:0] uid_part;
        logic [2:0]  uid_part_bytes;
        logic [7:0]  tag_sak;
        logic [1:0]  uid_size;
        logic [2:0]  error_code;
        logic        last;
    } res_t;

    function automatic logic [2:0] status_err(logic [2:0] st);
        logic [2:0] e;
        if (st inside {ST_TX_ERR, ST_TX_TIMEOUT})
            e = ERR_TX_FAIL;
        else if (st == ST_RX_TIMEOUT)
            e = ERR_NO_REPLY;
        else
            e = ERR_OTHER;
        return e;
    endfunction

    function automatic logic [15:0] crc_a_byte(logic [7:0] b);
        logic [15:0] ch;
        ch = {8'h00, b ^ CRC_A_PRESET[7:0]};
        ch = ch ^ ((ch << 4) & 16'h00FF);
        return (CRC_A_PRESET >> 8) ^ (ch << 8) ^ (ch << 3) ^ (ch >> 4);
    endfunction

    function automatic logic [7:0] bcc_of(logic [31:0] u);
        return u[7:0] ^ u[15:8] ^ u[23:16] ^ u[31:24];
    endfunction

    function automatic res_t mk_frame(logic [55:0] d, logic [2:0] nb, logic [2:0] lb,
                                      logic crc);
        res_t r;
        r = '0;
        r.result_kind     = KIND_FRAME;
        r.frame_data      = d;
        r.frame_bytes     = nb;
        r.frame_last_bits = lb;
        r.append_crc      = crc;
        return r;
    endfunction

    function automatic res_t mk_fail(logic [2:0] err);
        res_t r;
        r = '0;
        r.result_kind = KIND_FAILED;
        r.error_code  = err;
        return r;
    endfunction

    function automatic res_t mk_frag(logic [31:0] uid, logic [2:0] ub);
        res_t r;
        r = '0;
        r.result_kind    = KIND_UID;
        r.uid_part       = uid;
        r.uid_part_bytes = ub;
        return r;
    endfunction

    function automatic res_t mk_found(logic [7:0] sak, logic [1:0] size);
        res_t r;
        r = '0;
        r.result_kind = KIND_FOUND;
        r.tag_sak     = sak;
        r.uid_size    = size;
        return r;
    endfunction

    function automatic logic [7:0] sel_code(logic [1:0] level);
        return SEL_CL1 + {5'd0, level - LEVEL_FIRST, 1'b0};
    endfunction

    // Anticollision frame: SEL, NVB and the known UID bits, cut to the NVB length
    function automatic res_t mk_ac(logic [7:0] nvb, logic [31:0] known, logic [1:0] level);
        logic [2:0]  tx;
        logic [55:0] d;
        tx = nvb[6:4] + {2'd0, (nvb[2:0] != 3'd0)};
        d  = {8'h00, known, nvb, sel_code(level)};
        for (int i = 0; i < 7; i++)
        begin
            if (3'(i) >= tx)
                d[8*i +: 8] = 8'h00;
        end
        return mk_frame(d, tx, nvb[2:0], 1'b0);
    endfunction

endpackage

[hw/rtl/nfca_in_if.sv]
// Input channel: start requests and transceiver replies.
interface nfca_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [2:0]  reply_status;
    logic [39:0] reply_data;
    logic [2:0]  collision_byte;
    logic [2:0]  collision_bit;

    modport source (output valid, req_type, reply_status, reply_data, collision_byte,
                    collision_bit, input ready);
    modport sink   (input valid, req_type, reply_status, reply_data, collision_byte,
                    collision_bit, output ready);
endinterface

[hw/rtl/nfca_out_if.sv]
// Output channel: frames, UID fragments and search outcome.
interface nfca_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [55:0] frame_data;
    logic [2:0]  frame_bytes;
    logic [2:0]  frame_last_bits;
    logic        append_crc;
    logic [31:0] uid_part;
    logic [2:0]  uid_part_bytes;
    logic [7:0]  tag_sak;
    logic [1:0]  uid_size;
    logic [2:0]  error_code;
    logic        last;

    modport source (output valid, result_kind, frame_data, frame_bytes, frame_last_bits,
                    append_crc, uid_part, uid_part_bytes, tag_sak, uid_size, error_code,
                    last, input ready);
    modport sink   (input valid, result_kind, frame_data, frame_bytes, frame_last_bits,
                    append_crc, uid_part, uid_part_bytes, tag_sak, uid_size, error_code,
                    last, output ready);
endinterface

[hw/rtl/nfc_a_anticollision_sequencer_core.sv]
// Type A anticollision / cascade select sequencer, top level.
// Flow: an input transfer is captured in the input register, decoded from there and
//   written to the result queue, which offers its first result; any second one follows.
// Throughput: one item per cycle while the 4-entry result queue has room for two results;
//   items with two results are limited by the output port, one result per cycle while ready.
// Reset (rst_n low, async): phase idle, cascade level 1, known UID 0, NVB 0x20, SAK 0.
module nfc_a_anticollision_sequencer_core
(
    input  logic           clk,
    input  logic           rst_n,
    nfca_in_if.sink        in_ch,
    nfca_out_if.source     out_ch
);

    // Input register
    logic        in_valid_reg;
    logic        in_req_type_reg;
    logic [2:0]  in_status_reg;
    logic [39:0] in_data_reg;
    logic [2:0]  in_cbyte_reg;
    logic [2:0]  in_cbit_reg;

    // Sequencer state
    nfca_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  level_reg, level_next;
    logic [31:0] known_reg, known_next;
    logic [7:0]  nvb_reg, nvb_next;
    logic [7:0]  sak_reg, sak_next;

    // Result queue
    nfca_pkg::res_t               fifo_reg [nfca_pkg::FIFO_DEPTH];
    logic [nfca_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [nfca_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [nfca_pkg::FIFO_CW-1:0] cnt_reg;

    logic           fire;
    logic           pop;
    logic [1:0]     nres;
    nfca_pkg::res_t r0, r1;

    // Anticollision reply decode
    logic [2:0]  first;
    logic [5:0]  kbits;
    logic [39:0] al_shift;
    logic [39:0] low_known;
    logic [39:0] al;
    logic [31:0] uid_rx;
    logic [7:0]  bcc_rx;
    logic [5:0]  pos;
    logic [5:0]  n_bits;
    logic [31:0] pos_mask;
    logic [31:0] known_col;
    logic [7:0]  nvb_col;
    logic [7:0]  sak_rx;
    logic [15:0] crc_rx;
    logic        pos_bad;

    assign fire        = in_valid_reg && (cnt_reg <= nfca_pkg::FIFO_CW'(nfca_pkg::FIFO_DEPTH - 2));
    assign in_ch.ready = !in_valid_reg || fire;
    assign pop         = out_ch.valid && out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_req_type_reg <= in_ch.req_type;
            in_status_reg   <= in_ch.reply_status;
            in_data_reg     <= in_ch.reply_data;
            in_cbyte_reg    <= in_ch.collision_byte;
            in_cbit_reg     <= in_ch.collision_bit;
        end
    end

    // Align reply bits to UID bit positions and drop bits already known
    assign first     = nvb_reg[6:4] - 3'd2;
    assign kbits     = {first, 3'b000} + {3'd0, nvb_reg[2:0]};
    assign al_shift  = in_data_reg << {first, 3'b000};
    assign low_known = (40'd1 << kbits) - 40'd1;
    assign al        = al_shift & ~low_known;
    assign uid_rx    = known_reg | al[31:0];
    assign bcc_rx    = al[39:32];

    // Collision: keep bits below the collided one, which is sent as 0
    assign pos       = {in_cbyte_reg - 3'd2, 3'b000} + {3'd0, in_cbit_reg};
    assign pos_bad   = (in_cbyte_reg < 3'd2) || (pos < kbits) || (pos >= 6'd32);
    assign pos_mask  = (32'd1 << pos[4:0]) - 32'd1;
    assign known_col = known_reg | (al[31:0] & pos_mask);
    assign n_bits    = pos + 6'd1;
    assign nvb_col   = {1'b0, n_bits[5:3] + 3'd2, 1'b0, n_bits[2:0]};

    assign sak_rx    = in_data_reg[7:0];
    assign crc_rx    = in_data_reg[23:8];

    always_comb
    begin
        phase_next = phase_reg;
        level_next = level_reg;
        known_next = known_reg;
        nvb_next   = nvb_reg;
        sak_next   = sak_reg;
        r0         = '0;
        r1         = '0;
        nres       = 2'd0;

        if (in_req_type_reg == nfca_pkg::REQ_START)
        begin
            level_next = nfca_pkg::LEVEL_FIRST;
            known_next = '0;
            nvb_next   = nfca_pkg::NVB_START;
            sak_next   = '0;
            r0         = nfca_pkg::mk_frame({48'd0, nfca_pkg::CMD_REQA}, 3'd1, 3'd7, 1'b0);
            nres       = 2'd1;
            phase_next = nfca_pkg::PH_ATQA;
        end
        else
        begin
            case (phase_reg)
                nfca_pkg::PH_ATQA:
                begin
                    nres = 2'd1;
                    if (in_status_reg == nfca_pkg::ST_OK ||
                        in_status_reg == nfca_pkg::ST_RX_COLL)
                    begin
                        r0         = nfca_pkg::mk_ac(nvb_reg, known_reg, level_reg);
                        phase_next = nfca_pkg::PH_AC;
                    end
                    else
                    begin
                        r0         = nfca_pkg::mk_fail(nfca_pkg::status_err(in_status_reg));
                        phase_next = nfca_pkg::PH_IDLE;
                    end
                end

                nfca_pkg::PH_AC:
                begin
                    nres = 2'd1;
                    if (in_status_reg == nfca_pkg::ST_OK)
                    begin
                        if (nfca_pkg::bcc_of(uid_rx) != bcc_rx)
                        begin
                            r0         = nfca_pkg::mk_fail(nfca_pkg::ERR_BCC);
                            phase_next = nfca_pkg::PH_IDLE;
                        end
                        else
                        begin
                            known_next = uid_rx;
                            nvb_next   = nfca_pkg::NVB_FULL;
                            r0 = nfca_pkg::mk_frame({bcc_rx, uid_rx, nfca_pkg::NVB_FULL,
                                                     nfca_pkg::sel_code(level_reg)},
                                                    3'd7, 3'd0, 1'b1);
                            phase_next = nfca_pkg::PH_SAK;
                        end
                    end
                    else if (in_status_reg == nfca_pkg::ST_RX_COLL)
                    begin
                        if (pos_bad)
                        begin
                            r0         = nfca_pkg::mk_fail(nfca_pkg::ERR_OTHER);
                            phase_next = nfca_pkg::PH_IDLE;
                        end
                        else
                        begin
                            known_next = known_col;
                            nvb_next   = nvb_col;
                            r0         = nfca_pkg::mk_ac(nvb_col, known_col, level_reg);
                            phase_next = nfca_pkg::PH_AC;
                        end
                    end
                    else
                    begin
                        r0         = nfca_pkg::mk_fail(nfca_pkg::status_err(in_status_reg));
                        phase_next = nfca_pkg::PH_IDLE;
                    end
                end

                nfca_pkg::PH_SAK:
                begin
                    nres = 2'd1;
                    if (in_status_reg != nfca_pkg::ST_OK)
                    begin
                        r0 = nfca_pkg::mk_fail((in_status_reg == nfca_pkg::ST_RX_COLL) ?
                                               nfca_pkg::ERR_SEL_COLL :
                                               nfca_pkg::status_err(in_status_reg));
                        phase_next = nfca_pkg::PH_IDLE;
                    end
                    else if (crc_rx != nfca_pkg::crc_a_byte(sak_rx))
                    begin
                        r0         = nfca_pkg::mk_fail(nfca_pkg::ERR_SAK_CRC);
                        phase_next = nfca_pkg::PH_IDLE;
                    end
                    else if (sak_rx[nfca_pkg::SAK_CASC_BIT])
                    begin
                        // UID bytes after the cascade tag, then next frame or failure
                        nres = 2'd2;
                        r0   = nfca_pkg::mk_frag({8'h00, known_reg[31:8]}, 3'd3);
                        if (level_reg >= nfca_pkg::LEVEL_LAST)
                        begin
                            r1         = nfca_pkg::mk_fail(nfca_pkg::ERR_CASC_OVF);
                            phase_next = nfca_pkg::PH_IDLE;
                        end
                        else
                        begin
                            level_next = level_reg + 2'd1;
                            known_next = '0;
                            nvb_next   = nfca_pkg::NVB_START;
                            r1 = nfca_pkg::mk_ac(nfca_pkg::NVB_START, 32'd0,
                                                 level_reg + 2'd1);
                            phase_next = nfca_pkg::PH_AC;
                        end
                    end
                    else
                    begin
                        nres       = 2'd2;
                        r0         = nfca_pkg::mk_frag(known_reg, 3'd4);
                        sak_next   = sak_rx;
                        r1 = nfca_pkg::mk_frame({40'd0, 8'h00, nfca_pkg::CMD_HLTA},
                                                3'd2, 3'd0, 1'b1);
                        phase_next = nfca_pkg::PH_HALT;
                    end
                end

                nfca_pkg::PH_HALT:
                begin
                    nres       = 2'd1;
                    phase_next = nfca_pkg::PH_IDLE;
                    if (in_status_reg == nfca_pkg::ST_OK)
                        r0 = nfca_pkg::mk_found(sak_reg, level_reg - nfca_pkg::LEVEL_FIRST);
                    else if (in_status_reg == nfca_pkg::ST_RX_TIMEOUT)
                        r0 = nfca_pkg::mk_fail(nfca_pkg::ERR_OTHER);
                    else
                        r0 = nfca_pkg::mk_fail(nfca_pkg::status_err(in_status_reg));
                end

                default:
                begin
                    // reply while idle: dropped
                    phase_next = nfca_pkg::PH_IDLE;
                end
            endcase
        end

        if (nres == 2'd1)
            r0.last = 1'b1;
        if (nres == 2'd2)
            r1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= nfca_pkg::PH_IDLE;
            level_reg <= nfca_pkg::LEVEL_FIRST;
            known_reg <= '0;
            nvb_reg   <= nfca_pkg::NVB_START;
            sak_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            level_reg <= level_next;
            known_reg <= known_next;
            nvb_reg   <= nvb_next;
            sak_reg   <= sak_next;
        end
    end

    // Result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (fire)
                wr_ptr_reg <= wr_ptr_reg + nfca_pkg::FIFO_AW'(nres);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (fire ? nfca_pkg::FIFO_CW'(nres) : '0)
                               - nfca_pkg::FIFO_CW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && nres != 2'd0)
            fifo_reg[wr_ptr_reg] <= r0;
        if (fire && nres == 2'd2)
            fifo_reg[wr_ptr_reg + 1'b1] <= r1;
    end

    assign out_ch.valid           = (cnt_reg != '0);
    assign out_ch.result_kind     = fifo_reg[rd_ptr_reg].result_kind;
    assign out_ch.frame_data      = fifo_reg[rd_ptr_reg].frame_data;
    assign out_ch.frame_bytes     = fifo_reg[rd_ptr_reg].frame_bytes;
    assign out_ch.frame_last_bits = fifo_reg[rd_ptr_reg].frame_last_bits;
    assign out_ch.append_crc      = fifo_reg[rd_ptr_reg].append_crc;
    assign out_ch.uid_part        = fifo_reg[rd_ptr_reg].uid_part;
    assign out_ch.uid_part_bytes  = fifo_reg[rd_ptr_reg].uid_part_bytes;
    assign out_ch.tag_sak         = fifo_reg[rd_ptr_reg].tag_sak;
    assign out_ch.uid_size        = fifo_reg[rd_ptr_reg].uid_size;
    assign out_ch.error_code      = fifo_reg[rd_ptr_reg].error_code;
    assign out_ch.last            = fifo_reg[rd_ptr_reg].last;

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= nfca_pkg::FIFO_CW'(nfca_pkg::FIFO_DEPTH))
        else $error("result queue overfilled");

    a_start_atqa: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (in_req_type_reg == nfca_pkg::REQ_START) |=> phase_reg == nfca_pkg::PH_ATQA)
        else $error("start did not enter ATQA wait");

    a_two_fill: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (nres == 2'd2) && !pop |=> cnt_reg >= nfca_pkg::FIFO_CW'(2))
        else $error("second result lost");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg >= nfca_pkg::LEVEL_FIRST && level_reg <= nfca_pkg::LEVEL_LAST)
        else $error("cascade level out of range");

endmodule
